/* rtl/ukst_pkg.sv */
// ----------------------------------------------------------------------------
// ukst_pkg
// Shared types and codes for the unique key set table: command and status
// codes, the input item and the result beat passed between modules.
// ----------------------------------------------------------------------------
package ukst_pkg;

  localparam int KEY_W    = 32;
  localparam int INDEX_W  = 8;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 3;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CHECK  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_DUP       = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_RANGE     = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [KEY_W-1:0]   key;
    logic [INDEX_W-1:0] index;
    logic               last;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic [COUNT_W-1:0] entry_count;
    logic [KEY_W-1:0]   read_key;
    logic               sets_equal;
  } result_t;

endpackage

/* rtl/unique_key_set_table.sv */
// Insert and check search the held entries to a hit or to the end; remove
// searches to the hit, then compacts one entry a cycle; read fetches one entry.
// One item at a time: a new item is taken only after the last result is handed
// on; the linear walk over the key store does one read a cycle.
// Reset: count, batch state and handshakes clear at once; the key store is
// not cleared, as only entries below the count are ever read.
// ----------------------------------------------------------------------------
// unique_key_set_table
// Ordered, packed set of distinct keys with insert, remove with compaction,
// batch equality check and indexed read. Output beat is held in a register.
// ----------------------------------------------------------------------------
module unique_key_set_table #(
  parameter int CAPACITY = 256,
  parameter int KEY_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       cmd_i,
  input  logic [ukst_pkg::KEY_W-1:0]       key_i,
  input  logic [ukst_pkg::INDEX_W-1:0]     index_i,
  input  logic                             last_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ukst_pkg::STATUS_W-1:0]    status_o,
  output logic [ukst_pkg::COUNT_W-1:0]     entry_count_o,
  output logic [ukst_pkg::KEY_W-1:0]       read_key_o,
  output logic                             sets_equal_o
);

  ukst_pkg::item_t   item;
  ukst_pkg::result_t res;
  ukst_pkg::result_t out_q;
  logic              res_valid;
  logic              res_ready;
  logic              out_valid_q;

  always_comb begin
    item.cmd   = ukst_pkg::cmd_e'(cmd_i);
    item.key   = key_i;
    item.index = index_i;
    item.last  = last_i;
  end

  ukst_ctrl #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_i),
    .item_ready_o (in_ready_o),
    .item_i       (item),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // take a new beat when the output register is empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign entry_count_o = out_q.entry_count;
  assign read_key_o    = out_q.read_key;
  assign sets_equal_o  = out_q.sets_equal;

endmodule

/* rtl/ukst_ram.sv */
// ----------------------------------------------------------------------------
// ukst_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module ukst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/ukst_ctrl.sv */
// ----------------------------------------------------------------------------
// ukst_ctrl
// Sequencer around the key store: linear search, append, compaction after a
// remove, batch membership tracking and indexed read.
// ----------------------------------------------------------------------------
module ukst_ctrl #(
  parameter int CAPACITY = 256,
  parameter int KEY_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  output logic              item_ready_o,
  input  ukst_pkg::item_t   item_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output ukst_pkg::result_t res_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 2);
  localparam int SW = (KEY_BITS < ukst_pkg::KEY_W) ? KEY_BITS : ukst_pkg::KEY_W;
  localparam int IW = (CW > ukst_pkg::INDEX_W) ? CW : ukst_pkg::INDEX_W;
  localparam int KW = ukst_pkg::KEY_W;
  localparam int NW = ukst_pkg::COUNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_RDREQ = 3'd3;
  localparam logic [2:0] S_RDDAT = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]                 state_q, state_d;
  ukst_pkg::cmd_e             cmd_q, cmd_d;
  logic [SW-1:0]              key_q, key_d;
  logic [ukst_pkg::INDEX_W-1:0] index_q, index_d;
  logic                       last_q, last_d;
  logic [CW-1:0]              ptr_q, ptr_d;
  logic                       chk_q, chk_d;
  logic [AW-1:0]              wa_q, wa_d;
  logic [CW-1:0]              held_q, held_d;
  logic                       ball_q, ball_d;
  logic [CW-1:0]              bcnt_q, bcnt_d;
  ukst_pkg::status_e          status_q, status_d;
  logic [KW-1:0]              rkey_q, rkey_d;
  logic                       equal_q, equal_d;

  logic          we;
  logic [AW-1:0] waddr;
  logic [SW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [SW-1:0] rdata;

  logic          hit;
  logic          ball_n;
  logic [CW-1:0] bcnt_n;

  ukst_ram #(
    .WIDTH (SW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign hit = chk_q && (rdata == key_q);

  // Batch bookkeeping for a check item, valid once the search has resolved.
  assign ball_n = ball_q && hit;
  assign bcnt_n = (bcnt_q == CW'(CAPACITY + 1)) ? bcnt_q : bcnt_q + CW'(1);

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    key_d    = key_q;
    index_d  = index_q;
    last_d   = last_q;
    ptr_d    = ptr_q;
    chk_d    = 1'b0;
    wa_d     = wa_q;
    held_d   = held_q;
    ball_d   = ball_q;
    bcnt_d   = bcnt_q;
    status_d = status_q;
    rkey_d   = rkey_q;
    equal_d  = equal_q;
    we       = 1'b0;
    waddr    = wa_q;
    wdata    = rdata;
    raddr    = ptr_q[AW-1:0];
    item_ready_o = 1'b0;
    res_valid_o  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          cmd_d    = item_i.cmd;
          key_d    = item_i.key[SW-1:0];
          index_d  = item_i.index;
          last_d   = item_i.last;
          ptr_d    = '0;
          status_d = ukst_pkg::ST_OK;
          rkey_d   = '0;
          equal_d  = 1'b0;
          state_d  = (item_i.cmd == ukst_pkg::CMD_READ) ? S_RDREQ : S_SCAN;
        end
      end

      S_SCAN: begin
        if (hit || (ptr_q >= held_q)) begin
          state_d = S_OUT;
          unique case (cmd_q)
            ukst_pkg::CMD_INSERT: begin
              if (hit) begin
                status_d = ukst_pkg::ST_DUP;
              end else if (held_q == CW'(CAPACITY)) begin
                status_d = ukst_pkg::ST_FULL;
              end else begin
                we     = 1'b1;
                waddr  = held_q[AW-1:0];
                wdata  = key_q;
                held_d = held_q + CW'(1);
              end
            end
            ukst_pkg::CMD_REMOVE: begin
              if (!hit) begin
                status_d = ukst_pkg::ST_NOT_FOUND;
              end else begin
                // wa_q holds the hit position; pull later entries down
                ptr_d   = CW'(wa_q) + CW'(1);
                state_d = S_SHIFT;
              end
            end
            ukst_pkg::CMD_CHECK: begin
              if (!hit) begin
                status_d = ukst_pkg::ST_NOT_FOUND;
              end
              if (last_q) begin
                equal_d = ball_n && (bcnt_n == held_q);
                ball_d  = 1'b1;
                bcnt_d  = '0;
              end else begin
                ball_d  = ball_n;
                bcnt_d  = bcnt_n;
              end
            end
            ukst_pkg::CMD_READ: begin
              status_d = ukst_pkg::ST_OK;
            end
          endcase
        end else begin
          raddr = ptr_q[AW-1:0];
          chk_d = 1'b1;
          wa_d  = ptr_q[AW-1:0];
          ptr_d = ptr_q + CW'(1);
        end
      end

      S_SHIFT: begin
        // write back the entry read last cycle one place lower
        if (chk_q) begin
          we    = 1'b1;
          waddr = wa_q;
          wdata = rdata;
        end
        if (ptr_q < held_q) begin
          raddr = ptr_q[AW-1:0];
          wa_d  = AW'(ptr_q - CW'(1));
          chk_d = 1'b1;
          ptr_d = ptr_q + CW'(1);
        end else begin
          held_d  = held_q - CW'(1);
          state_d = S_OUT;
        end
      end

      S_RDREQ: begin
        if (IW'(index_q) < IW'(held_q)) begin
          raddr   = AW'(index_q);
          state_d = S_RDDAT;
        end else begin
          status_d = ukst_pkg::ST_RANGE;
          state_d  = S_OUT;
        end
      end

      S_RDDAT: begin
        rkey_d  = KW'(rdata);
        state_d = S_OUT;
      end

      S_OUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.status      = status_q;
    res_o.entry_count = NW'(held_q);
    res_o.read_key    = rkey_q;
    res_o.sets_equal  = equal_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      chk_q   <= 1'b0;
      held_q  <= '0;
      ball_q  <= 1'b1;
      bcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      chk_q   <= chk_d;
      held_q  <= held_d;
      ball_q  <= ball_d;
      bcnt_q  <= bcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    index_q  <= index_d;
    last_q   <= last_d;
    ptr_q    <= ptr_d;
    wa_q     <= wa_d;
    status_q <= status_d;
    rkey_q   <= rkey_d;
    equal_q  <= equal_d;
  end

endmodule
